FILE: design/rsq_pkg.sv
// Types and constants for the range sample qualifier.
// No dependencies.
`timescale 1ns / 1ps
package rsq_pkg;
  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_BUS_ERR = 2'd1,
    OP_POLL    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_VALID   = 3'd0,
    ST_RANGE   = 3'd1,
    ST_QUALITY = 3'd2,
    ST_BUS     = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_MIN_DIST  = 3'd0,
    REG_MAX_DIST  = 3'd1,
    REG_EMERG     = 3'd2,
    REG_TIMEOUT   = 3'd3,
    REG_TARGET    = 3'd4
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SORT,
    S_CHECK,
    S_DIV1_START,
    S_DIV1,
    S_DIV2_START,
    S_DIV2,
    S_FINISH,
    S_OUT
  } fsm_e;

  localparam logic [15:0] ScaleMul    = 16'd2011;
  localparam logic [31:0] ScaleRound  = 32'h0000_0400;
  localparam logic [7:0]  GoodStatus  = 8'd9;
  localparam logic [15:0] SpadFallbk  = 16'h8000;
  localparam logic [15:0] InvalidDist = 16'hFFFF;
  localparam logic [7:0]  RunMax      = 8'hFF;
  localparam logic [7:0]  DiagBus     = 8'd1;
  localparam logic [7:0]  DiagRange   = 8'd2;
  localparam logic [7:0]  DiagTimeout = 8'd3;

  typedef struct packed {
    logic [1:0]  sensor_out;
    logic [15:0] range_mm;
    logic [2:0]  status_code;
    logic        emergency;
    logic [7:0]  sequence_number;
    logic [7:0]  error_run;
    logic        diag_valid;
    logic [7:0]  diag_code;
    logic        spad_write;
    logic [15:0] spad_word;
    logic [31:0] stamp_ms;
  } result_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  sensor_index;
    logic [31:0] now_ms;
    logic [7:0]  range_status;
    logic [7:0]  stream_cnt;
    logic [15:0] raw_range;
    logic [15:0] spad_num;
    logic [15:0] amb_rate;
    logic [15:0] sig_rate;
  } sample_t;
endpackage

FILE: design/rsq_if.sv
// Valid/ready channel interfaces for sample and result words.
// Depends on rsq_pkg.
`timescale 1ns / 1ps
interface rsq_in_if;
  import rsq_pkg::*;
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsq_out_if;
  import rsq_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/rsq_ram.sv
// Generic single-port write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rsq_ram #(
  parameter int Width = 16,
  parameter int Depth = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: design/rsq_div.sv
// Restoring divider, 32 by 32 bits, one quotient bit a cycle.
// Depends on nothing; started by the sequencer in range_sample_qualifier.
`timescale 1ns / 1ps
module rsq_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quotient_o
);
  logic [31:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] trial;

  assign trial = {rem_q[31:0], quo_q[31]};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = 6'd32;
    end else if (cnt_q != '0) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;
endmodule

FILE: design/range_sample_qualifier.sv
// Range sample qualifier: per-sensor median filter, limit check and spad control.
// Depends on rsq_pkg, rsq_if, rsq_ram and rsq_div.
//
// Usage: event words arrive on in_ch (valid/ready); each gives zero or one
// result word on out_ch. Configuration is written through cfg_we_i/cfg_idx_i/
// cfg_data_i while the block is idle.
// Flow: an item is taken only in the idle state. A good sample writes the
// window memory, then reads the filled entries back one a cycle, then runs
// a selection sort, one compare a cycle; a valid result then runs up to two
// 32-bit divisions through the one shared divider. The next word is taken
// in the cycle after the result word leaves.
// Result words wait in an output register; while the receiver stalls, the
// block holds and accepts no new word.
// Reset clears all per-sensor counters, flags and configuration to their
// defaults; the window memory needs no clearing since only filled entries
// are read.
`timescale 1ns / 1ps
module range_sample_qualifier
  import rsq_pkg::*;
#(
  parameter int SENSOR_COUNT = 3,
  parameter int WINDOW_DEPTH = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  rsq_in_if.sink      in_ch,
  rsq_out_if.source   out_ch
);
  localparam int SW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int WW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int RW = FW + 1;
  localparam int MD = SENSOR_COUNT * WINDOW_DEPTH;
  localparam int MW = (MD > 1) ? $clog2(MD) : 1;
  localparam logic [FW-1:0] WinMax = FW'(WINDOW_DEPTH);

  // configuration
  logic [15:0] min_q, max_q, emerg_q, tmo_q, target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= 16'd50;
      max_q    <= 16'd3000;
      emerg_q  <= 16'd300;
      tmo_q    <= 16'd200;
      target_q <= 16'd2560;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_DIST: min_q    <= cfg_data_i;
        REG_MAX_DIST: max_q    <= cfg_data_i;
        REG_EMERG:    emerg_q  <= cfg_data_i;
        REG_TIMEOUT:  tmo_q    <= cfg_data_i;
        REG_TARGET:   target_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-sensor state
  logic [FW-1:0] fill_q [SENSOR_COUNT];
  logic [WW-1:0] pos_q  [SENSOR_COUNT];
  logic [7:0]    seq_q  [SENSOR_COUNT];
  logic [7:0]    run_q  [SENSOR_COUNT];
  logic [31:0]   good_q [SENSOR_COUNT];
  logic          tout_q [SENSOR_COUNT];

  fsm_e        state_q, state_d;
  sample_t     item_q;
  logic [SW-1:0] sen;
  logic [15:0] scaled;
  logic [15:0] vals_q [WINDOW_DEPTH];
  logic [FW-1:0] n_q;
  logic [FW-1:0] i_q, j_q;
  logic [RW-1:0] rd_q;
  logic [15:0] med;
  logic [15:0] med_q;
  logic        fire_q;
  logic        ovalid_q;
  result_t     res_q;

  assign sen = item_q.sensor_index[SW-1:0];
  assign med = vals_q[WW'(n_q >> 1)];

  // window memory
  logic          ram_we;
  logic [MW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_rdata;
  logic [31:0]   scaled_full;

  assign scaled_full = 32'(item_q.raw_range) * 32'(ScaleMul) + ScaleRound;
  assign scaled = scaled_full[26:11];

  rsq_ram #(.Width(16), .Depth(MD)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (scaled),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // divider
  logic        div_start, div_busy;
  logic [31:0] div_a, div_b, div_q;

  rsq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  logic accept;
  logic good_sample, sen_ok, op_ok, poll_fire;
  logic [31:0] elapsed;
  logic [16:0] rate_sum;
  logic [15:0] rate_sat;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_q == S_IDLE) && !ovalid_q;
  assign sen_ok = (32'(item_q.sensor_index) < 32'(SENSOR_COUNT));
  assign op_ok  = (item_q.operation != 2'd3);
  assign good_sample = (item_q.range_status == GoodStatus) && (item_q.stream_cnt != '0);
  assign elapsed = item_q.now_ms - good_q[sen];
  assign poll_fire = (elapsed >= 32'(tmo_q)) && !tout_q[sen];
  assign rate_sum = 17'(item_q.amb_rate) + 17'(item_q.sig_rate);
  assign rate_sat = rate_sum[16] ? 16'hFFFF : rate_sum[15:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_READ;
      S_READ: begin
        if (!sen_ok || !op_ok) begin
          state_d = S_IDLE;
        end else if (item_q.operation == OP_SAMPLE && good_sample) begin
          if (rd_q != '0 && rd_q == RW'(n_q) + RW'(1)) state_d = S_SORT;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SORT: begin
        if (32'(i_q) + 1 >= 32'(n_q)) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (med >= min_q && med <= max_q) state_d = S_DIV1_START;
        else state_d = S_FINISH;
      end
      S_DIV1_START: state_d = (item_q.spad_num == '0) ? S_FINISH : S_DIV1;
      S_DIV1: if (!div_busy) state_d = S_DIV2_START;
      S_DIV2_START: state_d = (div_q == '0) ? S_FINISH : S_DIV2;
      S_DIV2: if (!div_busy) state_d = S_FINISH;
      S_FINISH: state_d = S_OUT;
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = MW'(32'(sen) * WINDOW_DEPTH + 32'(pos_q[sen]));
    ram_raddr = MW'(32'(sen) * WINDOW_DEPTH + 32'(rd_q));
    div_start = 1'b0;
    div_a     = {rate_sat, 16'h0000};
    div_b     = 32'(item_q.spad_num);
    case (state_q)
      S_READ: begin
        // write the new value first, then read it back with the old ones
        ram_we = sen_ok && op_ok && item_q.operation == OP_SAMPLE && good_sample
                 && rd_q == '0;
        ram_raddr = MW'(32'(sen) * WINDOW_DEPTH + 32'(rd_q == '0 ? '0 : rd_q - RW'(1)));
      end
      S_DIV1_START: div_start = (item_q.spad_num != '0);
      S_DIV2_START: begin
        div_start = (div_q != '0);
        div_a     = {target_q, 16'h0000};
        div_b     = div_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      fire_q   <= 1'b0;
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        fill_q[s] <= '0;
        pos_q[s]  <= '0;
        seq_q[s]  <= '0;
        run_q[s]  <= '0;
        good_q[s] <= '0;
        tout_q[s] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
      if (state_q == S_READ && ram_we) begin
        pos_q[sen] <= (32'(pos_q[sen]) + 1 >= WINDOW_DEPTH) ? '0 : pos_q[sen] + WW'(1);
        if (fill_q[sen] != WinMax) fill_q[sen] <= fill_q[sen] + FW'(1);
      end
      if (state_q == S_FINISH) begin
        // keep the poll decision, the timeout flag changes below
        fire_q <= poll_fire;
        case (item_q.operation)
          OP_POLL: begin
            if (poll_fire) begin
              if (run_q[sen] != RunMax) run_q[sen] <= run_q[sen] + 8'd1;
              tout_q[sen] <= 1'b1;
              seq_q[sen]  <= seq_q[sen] + 8'd1;
            end
          end
          OP_BUS_ERR: begin
            if (run_q[sen] != RunMax) run_q[sen] <= run_q[sen] + 8'd1;
            tout_q[sen] <= 1'b0;
            seq_q[sen]  <= seq_q[sen] + 8'd1;
          end
          default: begin
            tout_q[sen] <= 1'b0;
            seq_q[sen]  <= seq_q[sen] + 8'd1;
            if (res_q.spad_write) begin
              run_q[sen]  <= '0;
              good_q[sen] <= item_q.now_ms;
            end
          end
        endcase
      end
      if (state_q == S_OUT) begin
        ovalid_q <= (item_q.operation != OP_POLL) || fire_q;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_ch.data;
    case (state_q)
      S_IDLE: begin
        // clear only on a new word, a waiting result must hold
        if (accept) begin
          rd_q <= '0;
          res_q.spad_write <= 1'b0;
          res_q.spad_word  <= '0;
        end
      end
      S_READ: begin
        if (rd_q == '0) begin
          n_q <= (fill_q[sen] != WinMax) ? fill_q[sen] + FW'(1) : fill_q[sen];
        end else if (rd_q != RW'(1)) begin
          // read data arrives in the cycle after its address
          vals_q[WW'(rd_q - RW'(2))] <= ram_rdata;
        end
        rd_q <= rd_q + RW'(1);
        i_q  <= '0;
        j_q  <= FW'(1);
      end
      S_SORT: begin
        // one compare-exchange a step of a selection sort
        if (32'(j_q) < 32'(n_q)) begin
          if (vals_q[WW'(j_q)] < vals_q[WW'(i_q)]) begin
            vals_q[WW'(i_q)] <= vals_q[WW'(j_q)];
            vals_q[WW'(j_q)] <= vals_q[WW'(i_q)];
          end
          if (32'(j_q) + 1 >= 32'(n_q)) begin
            i_q <= i_q + FW'(1);
            j_q <= i_q + FW'(2);
          end else begin
            j_q <= j_q + FW'(1);
          end
        end else begin
          i_q <= i_q + FW'(1);
          j_q <= i_q + FW'(2);
        end
      end
      S_CHECK: med_q <= med;
      S_DIV1_START: begin
        res_q.spad_write <= 1'b1;
        res_q.spad_word  <= SpadFallbk;
      end
      S_DIV2: begin
        if (!div_busy) res_q.spad_word <= (div_q[31:16] != '0) ? 16'hFFFF : div_q[15:0];
      end
      S_OUT: begin
        res_q.sensor_out      <= item_q.sensor_index;
        res_q.stamp_ms        <= item_q.now_ms;
        res_q.sequence_number <= seq_q[sen];
        res_q.error_run       <= run_q[sen];
        res_q.range_mm        <= InvalidDist;
        res_q.emergency       <= 1'b0;
        res_q.diag_valid      <= 1'b1;
        case (item_q.operation)
          OP_POLL: begin
            res_q.status_code <= ST_TIMEOUT;
            res_q.diag_code   <= DiagTimeout;
          end
          OP_BUS_ERR: begin
            res_q.status_code <= ST_BUS;
            res_q.diag_code   <= DiagBus;
          end
          default: begin
            if (!good_sample) begin
              res_q.status_code <= ST_QUALITY;
              res_q.diag_code   <= item_q.range_status;
            end else if (res_q.spad_write) begin
              res_q.status_code <= ST_VALID;
              res_q.diag_code   <= '0;
              res_q.diag_valid  <= 1'b0;
              res_q.range_mm    <= med_q;
              res_q.emergency   <= (med_q <= emerg_q);
            end else begin
              res_q.status_code <= ST_RANGE;
              res_q.diag_code   <= DiagRange;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  assign out_ch.valid = ovalid_q;
  assign out_ch.data  = res_q;

  // the divider never runs outside its two states
  a_div_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == S_DIV1 || state_q == S_DIV2))
    else $error("divider busy outside division states");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !ovalid_q && state_q == S_IDLE)
    else $error("word accepted while busy");
  a_valid_spad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && res_q.status_code == ST_VALID) |-> res_q.spad_write)
    else $error("valid result without spad word");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ch.ready) |=> ovalid_q && $stable(res_q))
    else $error("stalled result changed");
endmodule
